### design/fqt_pkg.sv
// Shared types, quantizer table and helpers for the 4x4 transform quantizer.
package fqt_pkg;

    typedef logic signed [8:0]  sample_t;
    typedef logic signed [11:0] tmp_t;
    typedef logic signed [15:0] coef_t;
    typedef logic signed [12:0] level_t;
    typedef logic [13:0]        mf_t;

    localparam int unsigned OFFSET_W = 24;
    localparam int unsigned PROD_W   = 29;
    localparam int unsigned LEVEL_MAX = 4095;

    typedef enum logic [1:0] {
        MF_EVEN  = 2'd0,
        MF_ODD   = 2'd1,
        MF_MIXED = 2'd2
    } mf_class_t;

    // per-row quantizer controls shared by all four lanes
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [3:0]          qdiv;
    } fqt_qctl_t;

    function automatic mf_class_t mf_class(input logic [1:0] row, input logic [1:0] col);
        mf_class_t c;
        if (!row[0] && !col[0])
            c = MF_EVEN;
        else if (row[0] && col[0])
            c = MF_ODD;
        else
            c = MF_MIXED;
        return c;
    endfunction

    function automatic mf_t mf_lookup(input logic [2:0] qmod, input mf_class_t c);
        logic [1:0] sel;
        mf_t        v;
        sel = (c == MF_EVEN) ? 2'd0 : ((c == MF_ODD) ? 2'd1 : 2'd2);
        unique case ({qmod, sel})
            {3'd0, 2'd0}: v = 14'd13107;
            {3'd0, 2'd1}: v = 14'd5243;
            {3'd0, 2'd2}: v = 14'd8066;
            {3'd1, 2'd0}: v = 14'd11916;
            {3'd1, 2'd1}: v = 14'd4660;
            {3'd1, 2'd2}: v = 14'd7490;
            {3'd2, 2'd0}: v = 14'd10082;
            {3'd2, 2'd1}: v = 14'd4194;
            {3'd2, 2'd2}: v = 14'd6554;
            {3'd3, 2'd0}: v = 14'd9362;
            {3'd3, 2'd1}: v = 14'd3647;
            {3'd3, 2'd2}: v = 14'd5825;
            {3'd4, 2'd0}: v = 14'd8192;
            {3'd4, 2'd1}: v = 14'd3355;
            {3'd4, 2'd2}: v = 14'd5243;
            {3'd5, 2'd0}: v = 14'd7282;
            {3'd5, 2'd1}: v = 14'd2893;
            {3'd5, 2'd2}: v = 14'd4559;
            default:      v = 14'd0;
        endcase
        return v;
    endfunction

    // qp/6 as (qp*43)>>8, exact for every 6-bit qp
    function automatic logic [3:0] qp_div6(input logic [5:0] qp);
        logic [11:0] p;
        p = {6'd0, qp} * 12'd43;
        return p[11:8];
    endfunction

    function automatic logic [2:0] qp_mod6(input logic [5:0] qp, input logic [3:0] qdiv);
        logic [5:0] six;
        logic [5:0] r;
        six = {qdiv, 2'b00} + {1'b0, qdiv, 1'b0};
        r   = qp - six;
        return r[2:0];
    endfunction

    // floor(2^n / 3) is the 0101... pattern shifted down
    function automatic logic [OFFSET_W-1:0] third_pow2(input logic [4:0] n);
        logic [31:0] v;
        logic [5:0]  sh;
        sh = 6'd32 - {1'b0, n};
        v  = 32'h5555_5555 >> sh;
        return v[OFFSET_W-1:0];
    endfunction

endpackage

### design/forward_4x4_transform_quantizer.sv
// Top level of the 4x4 forward integer transform and quantizer.
//
// Input stream: one request carries one row of four residual samples
// (s_tdata) and the intra flag (s_tuser); qp and intra are taken from the
// first row of each block and held. Rows 0 to 2 only fill a row buffer.
// The fourth row copies the whole block into a working bank, and a row
// sequencer then reads that bank one coefficient row per cycle, unless the
// receiver stalls, through four column lanes, a row merge and four quantizer lanes.
// Output stream: four rows of quantized levels per block, m_tlast on the
// fourth. The first row appears once it has passed the bank, the stage-A
// registers, the product register and the level register; the rest follow
// one per cycle while the receiver takes them, so blocks follow back to back;
// the working bank and the pipeline overlap with the next block's first three rows.
// Reset clears the row counter, held qp/intra, the sequencer and all valid
// bits. When the receiver stalls, the whole result pipeline holds; rows 0
// to 2 of the next block are still taken, the fourth waits until the bank
// is free and the pipeline moves.
module forward_4x4_transform_quantizer
    import fqt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // sample0, sample1, sample2, sample3, qp, zero pad
    input  logic        s_tuser,  // intra
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // level0, level1, level2, level3, zero pad
    output logic        m_tlast
);

    sample_t    in_sample [4];
    logic [5:0] in_qp;
    logic       in_accept;
    logic       adv;

    logic [1:0] row_count_reg;
    logic [5:0] held_qp_reg;
    logic       held_intra_reg;
    sample_t    rowbuf_reg [3][4];

    sample_t    bank_reg [4][4];
    logic [3:0] bank_qdiv_reg;
    logic [2:0] bank_mod_reg;
    logic       bank_intra_reg;
    logic       busy_reg;
    logic [1:0] seq_reg;
    logic       capture;

    logic [3:0] cap_qdiv;
    logic [4:0] off_n;

    tmp_t       lane_tmp [4];
    coef_t      merge_coef [4];
    fqt_qctl_t  qctl_next;

    logic       a_valid_reg;
    logic       a_last_reg;
    coef_t      a_coef_reg [4];
    mf_t        a_mf_reg [4];
    fqt_qctl_t  a_qctl_reg;

    logic       b_valid_reg;
    logic       b_last_reg;
    logic       c_valid_reg;
    logic       c_last_reg;
    level_t     lane_level [4];

    genvar g;

    for (g = 0; g < 4; g++)
    begin : g_unpack
        assign in_sample[g] = s_tdata[9*g +: 9];
    end
    assign in_qp = s_tdata[41:36];

    assign adv       = !c_valid_reg || m_tready;
    assign s_tready  = (row_count_reg != 2'd3) || (adv && (!busy_reg || seq_reg == 2'd3));
    assign in_accept = s_tvalid && s_tready;
    assign capture   = in_accept && (row_count_reg == 2'd3);

    // input side: row counter and held block controls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= 2'd0;
            held_qp_reg    <= 6'd0;
            held_intra_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            row_count_reg <= row_count_reg + 2'd1;
            if (row_count_reg == 2'd0)
            begin
                held_qp_reg    <= in_qp;
                held_intra_reg <= s_tuser;
            end
        end
    end

    assign cap_qdiv = qp_div6(held_qp_reg);

    always_ff @(posedge clk)
    begin
        if (in_accept && row_count_reg != 2'd3)
            rowbuf_reg[row_count_reg] <= in_sample;
        if (capture)
        begin
            bank_reg[0]    <= rowbuf_reg[0];
            bank_reg[1]    <= rowbuf_reg[1];
            bank_reg[2]    <= rowbuf_reg[2];
            bank_reg[3]    <= in_sample;
            bank_qdiv_reg  <= cap_qdiv;
            bank_mod_reg   <= qp_mod6(held_qp_reg, cap_qdiv);
            bank_intra_reg <= held_intra_reg;
        end
    end

    // row sequencer over the working bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            seq_reg  <= 2'd0;
        end
        else if (capture)
        begin
            busy_reg <= 1'b1;
            seq_reg  <= 2'd0;
        end
        else if (adv && busy_reg)
        begin
            seq_reg <= seq_reg + 2'd1;
            if (seq_reg == 2'd3)
                busy_reg <= 1'b0;
        end
    end

    for (g = 0; g < 4; g++)
    begin : g_col
        sample_t col [4];
        assign col[0] = bank_reg[0][g];
        assign col[1] = bank_reg[1][g];
        assign col[2] = bank_reg[2][g];
        assign col[3] = bank_reg[3][g];

        fqt_col_lane u_col (
            .x   (col),
            .row (seq_reg),
            .y   (lane_tmp[g])
        );
    end

    fqt_row_merge u_merge (
        .tmp  (lane_tmp),
        .coef (merge_coef)
    );

    // inter rounding uses 2^(qbits-1)/3
    assign off_n = bank_intra_reg ? (5'd15 + {1'b0, bank_qdiv_reg})
                                  : (5'd14 + {1'b0, bank_qdiv_reg});
    assign qctl_next.offset = third_pow2(off_n);
    assign qctl_next.qdiv   = bank_qdiv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_coef_reg <= merge_coef;
            a_qctl_reg <= qctl_next;
            for (int j = 0; j < 4; j++)
                a_mf_reg[j] <= mf_lookup(bank_mod_reg, mf_class(seq_reg, 2'(j)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
            c_valid_reg <= 1'b0;
            c_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= busy_reg;
            a_last_reg  <= busy_reg && (seq_reg == 2'd3);
            b_valid_reg <= a_valid_reg;
            b_last_reg  <= a_last_reg;
            c_valid_reg <= b_valid_reg;
            c_last_reg  <= b_last_reg;
        end
    end

    for (g = 0; g < 4; g++)
    begin : g_quant
        fqt_quant_lane u_quant (
            .clk   (clk),
            .adv   (adv),
            .coef  (a_coef_reg[g]),
            .mf    (a_mf_reg[g]),
            .qctl  (a_qctl_reg),
            .level (lane_level[g])
        );
    end

    assign m_tvalid = c_valid_reg;
    assign m_tlast  = c_last_reg;
    assign m_tdata  = {4'd0, lane_level[3], lane_level[2], lane_level[1], lane_level[0]};

`ifndef SYNTHESIS
    // the fourth row only lands in the bank once the sequencer has let go of it
    assert property (@(posedge clk) disable iff (!rst_n)
        capture |-> adv && (!busy_reg || seq_reg == 2'd3))
        else $error("bank overwritten while rows still pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        adv && busy_reg |=> a_valid_reg)
        else $error("sequencer row lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        adv && !busy_reg |=> !a_valid_reg)
        else $error("row issued with idle sequencer");

    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && a_last_reg |-> !busy_reg || seq_reg == 2'd0)
        else $error("last row issued with rows still left in bank");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(capture))
        else $error("sequencer started without a full block");
`endif

endmodule

### design/fqt_col_lane.sv
// One column lane: selected output of the vertical 1-D core transform.
module fqt_col_lane
    import fqt_pkg::*;
(
    input  sample_t    x [4],
    input  logic [1:0] row,
    output tmp_t       y
);

    tmp_t s0, s1, s2, s3;

    assign s0 = {{3{x[0][8]}}, x[0]};
    assign s1 = {{3{x[1][8]}}, x[1]};
    assign s2 = {{3{x[2][8]}}, x[2]};
    assign s3 = {{3{x[3][8]}}, x[3]};

    always_comb
    begin
        unique case (row)
            2'd0:    y = s0 + s1 + s2 + s3;
            2'd1:    y = (s0 <<< 1) + s1 - s2 - (s3 <<< 1);
            2'd2:    y = s0 - s1 - s2 + s3;
            2'd3:    y = s0 - (s1 <<< 1) + (s2 <<< 1) - s3;
            default: y = '0;
        endcase
    end

endmodule

### design/fqt_row_merge.sv
// Merges the four column-lane results with the horizontal 1-D core transform.
module fqt_row_merge
    import fqt_pkg::*;
(
    input  tmp_t  tmp  [4],
    output coef_t coef [4]
);

    coef_t t0, t1, t2, t3;

    assign t0 = {{4{tmp[0][11]}}, tmp[0]};
    assign t1 = {{4{tmp[1][11]}}, tmp[1]};
    assign t2 = {{4{tmp[2][11]}}, tmp[2]};
    assign t3 = {{4{tmp[3][11]}}, tmp[3]};

    assign coef[0] = t0 + t1 + t2 + t3;
    assign coef[1] = (t0 <<< 1) + t1 - t2 - (t3 <<< 1);
    assign coef[2] = t0 - t1 - t2 + t3;
    assign coef[3] = t0 - (t1 <<< 1) + (t2 <<< 1) - t3;

endmodule

### design/fqt_quant_lane.sv
// Quantizer lane: magnitude times MF plus offset, then shift, clamp and sign.
module fqt_quant_lane
    import fqt_pkg::*;
(
    input  logic      clk,
    input  logic      adv,
    input  coef_t     coef,
    input  mf_t       mf,
    input  fqt_qctl_t qctl,
    output level_t    level
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              neg_reg;
    logic [3:0]        qdiv_reg;
    level_t            level_reg;
    level_t            level_next;

    coef_t             mag_full;
    logic [13:0]       mag;
    logic [27:0]       mult;
    logic [4:0]        qbits;
    logic [PROD_W-1:0] shifted;
    logic [11:0]       sat;

    // |coef| never exceeds 9216, so 14 bits hold it
    assign mag_full  = coef[15] ? -coef : coef;
    assign mag       = mag_full[13:0];
    assign mult      = mag * mf;
    assign prod_next = {1'b0, mult} + {{(PROD_W-OFFSET_W){1'b0}}, qctl.offset};

    assign qbits   = 5'd15 + {1'b0, qdiv_reg};
    assign shifted = prod_reg >> qbits;
    assign sat     = (shifted > PROD_W'(LEVEL_MAX)) ? 12'(LEVEL_MAX) : shifted[11:0];
    assign level_next = neg_reg ? -{1'b0, sat} : {1'b0, sat};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            neg_reg   <= coef[15];
            qdiv_reg  <= qctl.qdiv;
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule
